### hdl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SC2HID_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define SC2HID_NEVER(lbl, clk, rst_n, cond, msg) \
    `SC2HID_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### hdl/sc2hid_pkg.sv
// Shared types, constants and functions of the scan code to HID report converter.
`default_nettype none

package sc2hid_pkg;

    localparam int KEY_SLOT_COUNT_DEF = 6;
    localparam int TABLE_DEPTH        = 128;
    localparam int TABLE_IDX_W        = 7;
    localparam int REPORT_KEYS        = 6;
    localparam int REPORT_W           = 8 * (REPORT_KEYS + 1);
    localparam int IDLE_W             = 10;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W          = 24;
    localparam int S_TUSER_W          = 3;

    localparam logic [1:0]        OP_POLL        = 2'd0;
    localparam logic [1:0]        OP_TICK        = 2'd1;
    localparam logic [1:0]        OP_TABLE_WR    = 2'd2;
    localparam logic [7:0]        USAGE_ROLLOVER = 8'h01;
    localparam logic [7:0]        BREAK_FIRST    = 8'h7F;
    localparam logic [IDLE_W-1:0] IDLE_RESET     = 10'd500;

    typedef struct packed {
        logic       is_tick;
        logic       byte_valid;
        logic       is_make;
        logic [7:0] usage;
        logic [7:0] mod_mask;
        logic       endpoint_ready;
    } t_cmd;

    function automatic logic [7:0] mod_mask(input logic [7:0] usage);
        logic [7:0] m;
        case (usage)
            8'hE0:   m = 8'h01;
            8'hE1:   m = 8'h02;
            8'hE2:   m = 8'h04;
            8'hE3:   m = 8'h08;
            8'hE5:   m = 8'h20;
            8'hE6:   m = 8'h40;
            8'hE7:   m = 8'h80;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### hdl/sc2hid_front.sv
// Front end: accepts input transactions, holds the translation table, classifies scan bytes.
`default_nettype none

module sc2hid_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // scan_byte[7:0], endpoint_ready[8], table_index[15:9], table_value[23:16]
    input  wire  [sc2hid_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // opcode[1:0], byte_valid[2]
    input  wire  [sc2hid_pkg::S_TUSER_W-1:0]   i_s_tuser,
    input  wire                                i_q_full,
    output logic                               o_q_push,
    output sc2hid_pkg::t_cmd                   o_q_cmd
);
    import sc2hid_pkg::*;

    logic [1:0]             opcode;
    logic                   byte_valid;
    logic [7:0]             scan_byte;
    logic                   endpoint_ready;
    logic [TABLE_IDX_W-1:0] table_index;
    logic [7:0]             table_value;
    logic                   accept;
    logic                   load;
    logic [7:0]             usage;

    logic [7:0]             r_table [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_tvld;
    logic [7:0]             r_rd;
    logic                   r_rd_vld;
    logic                   r_stg_valid;
    logic                   r_stg_tick;
    logic                   r_stg_bv;
    logic                   r_stg_make;
    logic                   r_stg_ep;

    assign opcode         = i_s_tuser[1:0];
    assign byte_valid     = i_s_tuser[2];
    assign scan_byte      = i_s_tdata[7:0];
    assign endpoint_ready = i_s_tdata[8];
    assign table_index    = i_s_tdata[15:9];
    assign table_value    = i_s_tdata[23:16];

    assign o_s_tready = !r_stg_valid || !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign load       = accept && (opcode == OP_POLL || opcode == OP_TICK);
    assign o_q_push   = r_stg_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (accept && opcode == OP_TABLE_WR) begin
            r_table[table_index] <= table_value;
        end
        if (accept) begin
            r_rd <= r_table[scan_byte[TABLE_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld      <= '0;
            r_rd_vld    <= 1'b0;
            r_stg_valid <= 1'b0;
        end else begin
            if (accept && opcode == OP_TABLE_WR) begin
                r_tvld[table_index] <= 1'b1;
            end
            if (accept) begin
                r_rd_vld <= r_tvld[scan_byte[TABLE_IDX_W-1:0]];
            end
            if (load) begin
                r_stg_valid <= 1'b1;
            end else if (o_q_push) begin
                r_stg_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_stg_tick <= (opcode == OP_TICK);
            r_stg_bv   <= byte_valid;
            r_stg_make <= (scan_byte < BREAK_FIRST);
            r_stg_ep   <= endpoint_ready;
        end
    end

    assign usage = r_rd_vld ? r_rd : 8'h00;

    always_comb begin
        o_q_cmd.is_tick        = r_stg_tick;
        o_q_cmd.byte_valid     = r_stg_bv;
        o_q_cmd.is_make        = r_stg_make;
        o_q_cmd.usage          = usage;
        o_q_cmd.mod_mask       = mod_mask(usage);
        o_q_cmd.endpoint_ready = r_stg_ep;
    end

endmodule

`default_nettype wire

### hdl/sc2hid_queue.sv
// Short command queue between the front end and the report engine.
`default_nettype none

`include "assert_macros.svh"

module sc2hid_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire sc2hid_pkg::t_cmd i_cmd,
    output logic                  o_full,
    output logic                  o_valid,
    output sc2hid_pkg::t_cmd      o_cmd,
    input  wire                   i_pop
);
    import sc2hid_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SC2HID_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && r_count == '0, "pop from empty queue")
    `SC2HID_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full")
    `SC2HID_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= QUEUE_CNT_W'(QUEUE_DEPTH), "bad count")

endmodule

`default_nettype wire

### hdl/sc2hid_back.sv
// Report engine: key slots, modifiers, report build, change and idle send rule, output register.
`default_nettype none

`include "assert_macros.svh"

module sc2hid_back #(
    parameter int KEY_SLOT_COUNT = sc2hid_pkg::KEY_SLOT_COUNT_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_q_valid,
    input  wire  sc2hid_pkg::t_cmd            i_q_cmd,
    output logic                              o_q_pop,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [sc2hid_pkg::IDLE_W-1:0]     i_cfg_data,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [sc2hid_pkg::REPORT_W-1:0]   o_m_tdata
);
    import sc2hid_pkg::*;

    logic [7:0]          r_mods;
    logic [7:0]          r_slots [KEY_SLOT_COUNT];
    logic [REPORT_W-1:0] r_last;
    logic [IDLE_W-1:0]   r_idle;
    logic [IDLE_W-1:0]   r_period;
    logic                r_out_valid;
    logic [REPORT_W-1:0] r_out_data;

    logic [7:0]          n_mods;
    logic [7:0]          n_slots [KEY_SLOT_COUNT];
    logic [IDLE_W-1:0]   n_idle;
    logic                found;
    logic                overflow;
    logic [2:0]          cnt;
    logic [REPORT_W-1:0] report;
    logic                due;
    logic                send;
    logic                emit;

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_q_pop     = i_q_valid && (i_q_cmd.is_tick || !r_out_valid || i_m_tready);

    always_comb begin
        n_mods   = r_mods;
        n_slots  = r_slots;
        found    = 1'b0;
        overflow = 1'b0;
        if (i_q_cmd.byte_valid && i_q_cmd.usage != 8'h00) begin
            if (i_q_cmd.is_make) begin
                if (i_q_cmd.mod_mask != 8'h00) begin
                    n_mods = r_mods | i_q_cmd.mod_mask;
                end else begin
                    for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                        if (!found && r_slots[i] == 8'h00) begin
                            n_slots[i] = i_q_cmd.usage;
                            found      = 1'b1;
                        end
                    end
                    overflow = !found;
                end
            end else begin
                if (i_q_cmd.mod_mask != 8'h00) begin
                    n_mods = r_mods & ~i_q_cmd.mod_mask;
                end else begin
                    for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                        if (!found && r_slots[i] == i_q_cmd.usage) begin
                            n_slots[i] = 8'h00;
                            found      = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        report      = '0;
        report[7:0] = n_mods;
        cnt         = '0;
        if (overflow) begin
            for (int k = 0; k < REPORT_KEYS; k++) begin
                report[8*(k+1) +: 8] = USAGE_ROLLOVER;
            end
        end else begin
            for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                if (n_slots[i] != 8'h00 && cnt < 3'(REPORT_KEYS)) begin
                    report[8*(32'(cnt)+1) +: 8] = n_slots[i];
                    cnt = cnt + 3'd1;
                end
            end
        end
    end

    always_comb begin
        due = (r_period != '0) && (r_idle == '0);
        if (i_q_cmd.is_tick) begin
            n_idle = (r_idle != '0) ? r_idle - 1'b1 : r_idle;
        end else begin
            n_idle = due ? r_period : r_idle;
        end
        send = (report != r_last) || due;
        emit = o_q_pop && !i_q_cmd.is_tick && i_q_cmd.endpoint_ready && send;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods      <= '0;
            r_last      <= '0;
            r_idle      <= '0;
            r_period    <= IDLE_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                r_slots[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (o_q_pop) begin
                r_idle <= n_idle;
                if (!i_q_cmd.is_tick) begin
                    r_mods  <= n_mods;
                    r_slots <= n_slots;
                end
            end
            if (emit) begin
                r_last      <= report;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= report;
        end
    end

    `SC2HID_ASSERT(a_out_is_last, i_clk, i_rst_n, r_out_valid |-> r_out_data == r_last, "stale")
    `SC2HID_NEVER(a_tick_emit, i_clk, i_rst_n, emit && i_q_cmd.is_tick, "tick produced a report")

endmodule

`default_nettype wire

### hdl/scancode_to_hid_keyboard_report_top.sv
// Top level of the scan code to USB HID boot keyboard report converter.
// A poll's report goes through the table read and staging registers, the command queue and the output register.
// Throughput: one input transaction per cycle unless the queue is full; the report output register stalls polls only.
// The translation table is one 128-entry memory with one registered read port per cycle.
// Reset (i_rst_n low, synchronous) marks every table entry unmapped, clears slots, modifiers,
// last report and idle counter, and loads the idle period with 500; no clearing pass.
`default_nettype none

module scancode_to_hid_keyboard_report_top #(
    parameter int KEY_SLOT_COUNT = sc2hid_pkg::KEY_SLOT_COUNT_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    // scan_byte[7:0], endpoint_ready[8], table_index[15:9], table_value[23:16]
    input  wire  [sc2hid_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // opcode[1:0], byte_valid[2]
    input  wire  [sc2hid_pkg::S_TUSER_W-1:0]  i_s_tuser,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [sc2hid_pkg::IDLE_W-1:0]     i_cfg_data,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // modifier_bits[7:0], key_code_0[15:8], key_code_1[23:16], key_code_2[31:24],
    // key_code_3[39:32], key_code_4[47:40], key_code_5[55:48]
    output logic [sc2hid_pkg::REPORT_W-1:0]   o_m_tdata
);
    import sc2hid_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;

    sc2hid_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in)
    );

    sc2hid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    sc2hid_back #(
        .KEY_SLOT_COUNT (KEY_SLOT_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out),
        .o_q_pop     (q_pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire

### test/report_checker.sv
// Checker that predicts HID boot reports from accepted scan transactions and compares them.
`timescale 1ns / 1ps

module report_checker #(
    parameter int KEY_SLOTS = sc2hid_pkg::KEY_SLOT_COUNT_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    input  wire                               i_s_tready,
    input  wire [sc2hid_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  wire [sc2hid_pkg::S_TUSER_W-1:0]   i_s_tuser,
    input  wire                               i_cfg_valid,
    input  wire                               i_cfg_ready,
    input  wire [sc2hid_pkg::IDLE_W-1:0]      i_cfg_data,
    input  wire                               i_m_tvalid,
    input  wire                               i_m_tready,
    input  wire [sc2hid_pkg::REPORT_W-1:0]    i_m_tdata,
    output int                                o_fail_count,
    output int                                o_pending
);
    import sc2hid_pkg::*;

    typedef struct packed {
        logic [REPORT_KEYS-1:0][7:0] keys;
        logic [7:0]                  mods;
    } t_report;

    logic [7:0]        usage_map [TABLE_DEPTH];
    logic [7:0]        pressed   [KEY_SLOTS];
    logic [7:0]        held_mods;
    t_report           last_report;
    logic [IDLE_W-1:0] idle_left;
    logic [IDLE_W-1:0] resend_period;
    t_report           report_q [$];

    task automatic absorb_transaction(input logic [1:0] op, input logic byte_vld,
                                      input logic [7:0] scan, input logic ep_rdy,
                                      input logic [6:0] tidx, input logic [7:0] tval);
        logic [7:0] usage;
        logic [7:0] mod_bit;
        logic       is_mod;
        logic       rollover;
        logic       done;
        logic       due;
        t_report    rpt;
        int         n;
        rollover = 1'b0;
        case (op)
            OP_TICK: begin
                if (idle_left != '0) idle_left = idle_left - 1'b1;
            end
            OP_TABLE_WR: begin
                usage_map[tidx] = tval;
            end
            OP_POLL: begin
                if (byte_vld) begin
                    usage   = usage_map[scan[6:0]];
                    is_mod  = (usage[7:3] == 5'b11100) && (usage[2:0] != 3'd4);
                    mod_bit = 8'd1 << usage[2:0];
                    if (usage != 8'h00) begin
                        if (scan < BREAK_FIRST) begin
                            if (is_mod) begin
                                held_mods = held_mods | mod_bit;
                            end else begin
                                rollover = 1'b1;
                                for (int s = 0; s < KEY_SLOTS; s++) begin
                                    if (rollover && pressed[s] == 8'h00) begin
                                        pressed[s] = usage;
                                        rollover   = 1'b0;
                                    end
                                end
                            end
                        end else if (is_mod) begin
                            held_mods = held_mods & ~mod_bit;
                        end else begin
                            done = 1'b0;
                            for (int s = 0; s < KEY_SLOTS; s++) begin
                                if (!done && pressed[s] == usage) begin
                                    pressed[s] = 8'h00;
                                    done       = 1'b1;
                                end
                            end
                        end
                    end
                end
                rpt      = '0;
                rpt.mods = held_mods;
                if (rollover) begin
                    for (int k = 0; k < REPORT_KEYS; k++) rpt.keys[k] = USAGE_ROLLOVER;
                end else begin
                    n = 0;
                    for (int s = 0; s < KEY_SLOTS; s++) begin
                        if (pressed[s] != 8'h00 && n < REPORT_KEYS) begin
                            rpt.keys[n] = pressed[s];
                            n++;
                        end
                    end
                end
                due = (rpt != last_report);
                if (resend_period != '0 && idle_left == '0) begin
                    idle_left = resend_period;
                    due       = 1'b1;
                end
                if (due && ep_rdy) begin
                    last_report = rpt;
                    report_q.push_back(rpt);
                end
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : watch
        t_report seen;
        t_report want;
        if (!i_rst_n) begin
            foreach (usage_map[i]) usage_map[i] = 8'h00;
            foreach (pressed[i]) pressed[i] = 8'h00;
            held_mods     = 8'h00;
            last_report   = '0;
            idle_left     = '0;
            resend_period = IDLE_RESET;
            report_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) resend_period = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                seen = i_m_tdata;
                if (report_q.size() == 0) begin
                    $error("report %h with none expected", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = report_q.pop_front();
                    if (seen.mods !== want.mods) begin
                        $error("modifier_bits: expected %02h, actual %02h", want.mods, seen.mods);
                        o_fail_count++;
                    end
                    for (int k = 0; k < REPORT_KEYS; k++) begin
                        if (seen.keys[k] !== want.keys[k]) begin
                            $error("key_code_%0d: expected %02h, actual %02h",
                                   k, want.keys[k], seen.keys[k]);
                            o_fail_count++;
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                absorb_transaction(i_s_tuser[1:0], i_s_tuser[2], i_s_tdata[7:0], i_s_tdata[8],
                                   i_s_tdata[15:9], i_s_tdata[23:16]);
            end
        end
        o_pending = report_q.size();
    end

endmodule

### test/tb_top.sv
// Testbench top: drives scan transactions, period writes and report back-pressure.
`timescale 1ns / 1ps

module tb_top;
    import sc2hid_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         PHASE_ITEMS = 70;
    localparam int         QUIET_LIMIT = 1500;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDLE_W-1:0]    cfg_data;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [REPORT_W-1:0]  m_tdata;
    int                   fail_count;
    int                   pending;
    int                   sent;

    logic [IDLE_W-1:0]    periods [6] = '{10'd0, 10'd1, 10'd1020, 10'd3, 10'd17, 10'd2};

    always #6 i_clk = ~i_clk;

    scancode_to_hid_keyboard_report_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    report_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Entered and left at a falling edge.
    task automatic send_item(input logic [1:0] op, input logic byte_vld, input logic [7:0] scan,
                             input logic ep_rdy, input logic [6:0] tidx, input logic [7:0] tval);
        int gap;
        gap = ((sent / 32) % 4 == 3) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = {byte_vld, op};
        s_tdata  = {tval, tidx, ep_rdy, scan};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic write_period(input logic [IDLE_W-1:0] value);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_usage();
        case ($urandom_range(0, 3))
            0:       return 8'hE0 + 8'($urandom_range(0, 7));
            3:       return 8'($urandom_range(0, 255));
            default: return 8'h04 + 8'($urandom_range(0, 5));
        endcase
    endfunction

    task automatic random_item();
        int         pick;
        logic [6:0] idx;
        logic [7:0] scan;
        logic       ep;
        pick = $urandom_range(0, 99);
        idx  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 15));
        scan = {1'($urandom_range(0, 1)), idx};
        if ($urandom_range(0, 15) == 0) scan = BREAK_FIRST;
        ep   = ($urandom_range(0, 3) != 0);
        if (pick < 45) begin
            send_item(OP_POLL, 1'b1, scan, ep, 7'($urandom), 8'($urandom));
        end else if (pick < 60) begin
            send_item(OP_POLL, 1'b0, 8'($urandom), ep, 7'($urandom), 8'($urandom));
        end else if (pick < 85) begin
            send_item(OP_TICK, 1'($urandom), 8'($urandom), 1'($urandom), 7'($urandom),
                      8'($urandom));
        end else if (pick < 93) begin
            send_item(OP_TABLE_WR, 1'($urandom), 8'($urandom), 1'($urandom), idx, pick_usage());
        end else begin
            send_item(OP_UNUSED, 1'($urandom), 8'($urandom), 1'($urandom), 7'($urandom),
                      8'($urandom));
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        sent      = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(OP_TABLE_WR, 1'b0, 8'h00, 1'b0, 7'd0, 8'h04);
        send_item(OP_TABLE_WR, 1'b0, 8'h00, 1'b0, 7'd127, 8'hFF);
        send_item(OP_TABLE_WR, 1'b0, 8'h00, 1'b0, 7'd1, 8'hE0);
        send_item(OP_TABLE_WR, 1'b0, 8'h00, 1'b0, 7'd2, 8'hE4);
        send_item(OP_TABLE_WR, 1'b0, 8'h00, 1'b0, 7'd3, 8'hE7);
        send_item(OP_TABLE_WR, 1'b0, 8'h00, 1'b0, 7'd4, 8'hFF);
        // idle expiry right after reset
        send_item(OP_POLL, 1'b0, 8'h00, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, 8'h00, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, 8'h01, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, 8'h03, 1'b0, 7'd0, 8'h00);
        // right control takes a key slot
        send_item(OP_POLL, 1'b1, 8'h02, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, 8'h7E, 1'b1, 7'd0, 8'h00);
        repeat (4) send_item(OP_POLL, 1'b1, 8'h00, 1'b1, 7'd0, 8'h00);
        // slots full: rollover report, then back to the packed one
        send_item(OP_POLL, 1'b1, 8'h02, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b0, 8'hFF, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, 8'h80, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, 8'hFF, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, 8'h04, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, BREAK_FIRST, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, 8'h81, 1'b1, 7'd0, 8'h00);
        send_item(OP_POLL, 1'b1, 8'h83, 1'b1, 7'd0, 8'h00);
        send_item(OP_TICK, 1'b1, 8'hFF, 1'b1, 7'd127, 8'hFF);
        send_item(OP_UNUSED, 1'b1, 8'hFF, 1'b1, 7'd127, 8'hFF);
        send_item(OP_TABLE_WR, 1'b0, 8'h00, 1'b0, 7'd0, 8'h00);

        foreach (periods[p]) begin
            write_period(periods[p]);
            if (p == 0) begin
                for (int i = 0; i < 16; i++) begin
                    send_item(OP_TABLE_WR, 1'b0, 8'h00, 1'b0, 7'(i), pick_usage());
                end
            end
            repeat (PHASE_ITEMS) random_item();
        end
        s_tvalid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("scancode_to_hid_keyboard_report_top: match");
        end else begin
            $display("scancode_to_hid_keyboard_report_top: mismatch");
        end
        $finish;
    end

    initial begin : report_sink
        int  stall;
        int  taken;
        bit  held;
        taken    = 0;
        held     = 1'b0;
        m_tready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            stall = ((taken / 25) % 3 == 2) ? 0 : $urandom_range(0, 15);
            // hold off long enough to back the block up into its input
            if (!held && taken == 30) begin
                held  = 1'b1;
                stall = 240;
            end
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready = 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("scancode_to_hid_keyboard_report_top: mismatch");
        $finish;
    end

endmodule
